### hw/rtl/y2p_pkg.sv
package y2p_pkg;

  // Configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH_PAIRS  = 1'b0,
    REG_HEIGHT_PAIRS = 1'b1
  } cfg_reg_t;

  // Reset values of the size registers
  localparam logic [CFG_W-1:0] WIDTH_PAIRS_RESET  = 11'd320;
  localparam logic [CFG_W-1:0] HEIGHT_PAIRS_RESET = 11'd240;

  // Line buffer entry: half U in the upper bits, half V in the lower bits
  localparam int HALF_W = 7;
  localparam int LINE_W = 2 * HALF_W;

  // Output queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_luma_first;
    logic [7:0]  out_luma_second;
    logic [10:0] pixel_row;
    logic [9:0]  col_pair;
    logic        chroma_valid;
    logic [7:0]  out_chroma_blue;
    logic [7:0]  out_chroma_red;
    logic        frame_end;
  } out_item_t;

  // Item handed from the front part to the back part in the cycle after the transfer
  typedef struct packed {
    logic [7:0]        luma_first;
    logic [7:0]        luma_second;
    logic [10:0]       pixel_row;
    logic [9:0]        col_pair;
    logic              odd_row;
    logic              frame_end;
    logic [HALF_W-1:0] blue_half;
    logic [HALF_W-1:0] red_half;
  } issue_t;

endpackage

### hw/rtl/yuyv_to_planar_420_converter.sv
// Converts a raster stream of packed 4:2:2 macropixels (Y0, U, Y1, V) into 4:2:0 form:
// every input transfer produces one output transfer carrying both luma samples with
// their row and column-pair position. On odd rows the output also carries the chroma
// pair averaged with the row above, as (even >> 1) + (odd >> 1); on even rows chroma
// is zero and chroma_valid is low. The block takes one macropixel per clock cycle
// while in_stall is low; a result passes through the issue register and the output
// queue before it appears. The one line buffer memory (MAX_PAIRS_PER_ROW entries of
// 14 bits) is written on even rows and read on odd rows through its single write port
// and single read port, which is enough for that rate. A four-entry output queue lets
// input keep flowing while the output side is stalled, until the queue fills. Sizes
// are given in pairs; zero counts as one and larger values saturate at the buffer
// limits. The line buffer needs no clearing pass, so items are accepted right after
// reset. Size registers may be written only while no transfer is in flight.
module yuyv_to_planar_420_converter import y2p_pkg::*; #(
  parameter int MAX_PAIRS_PER_ROW = 1024,
  parameter int MAX_ROW_PAIRS     = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  localparam int AW = $clog2(MAX_PAIRS_PER_ROW);

  logic              room;
  logic              line_we;
  logic              line_re;
  logic [AW-1:0]     line_addr;
  logic [LINE_W-1:0] line_wdata;
  logic [LINE_W-1:0] line_rdata;
  logic              issue_valid;
  issue_t            issue;

  // Front part: counters, size registers and line buffer access.
  y2p_front #(
    .MAX_PAIRS_PER_ROW (MAX_PAIRS_PER_ROW),
    .MAX_ROW_PAIRS     (MAX_ROW_PAIRS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .room        (room),
    .line_we     (line_we),
    .line_re     (line_re),
    .line_addr   (line_addr),
    .line_wdata  (line_wdata),
    .issue_valid (issue_valid),
    .issue       (issue)
  );

  // Half-chroma line buffer.
  y2p_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_PAIRS_PER_ROW)
  ) u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_addr),
    .wdata (line_wdata),
    .re    (line_re),
    .raddr (line_addr),
    .rdata (line_rdata)
  );

  // Back part: chroma averaging and output queue.
  y2p_back u_back (
    .clk         (clk),
    .rst         (rst),
    .issue_valid (issue_valid),
    .issue       (issue),
    .line_rdata  (line_rdata),
    .room        (room),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

### hw/rtl/y2p_ram.sv
module y2p_ram import y2p_pkg::*; #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/y2p_front.sv
module y2p_front import y2p_pkg::*; #(
  parameter int MAX_PAIRS_PER_ROW = 1024,
  parameter int MAX_ROW_PAIRS     = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [CFG_IDX_W-1:0]                 cfg_index,
  input  logic [CFG_W-1:0]                     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  in_item_t                             in_data,
  input  logic                                 room,
  output logic                                 line_we,
  output logic                                 line_re,
  output logic [$clog2(MAX_PAIRS_PER_ROW)-1:0] line_addr,
  output logic [LINE_W-1:0]                    line_wdata,
  output logic                                 issue_valid,
  output issue_t                               issue
);

  localparam int CW    = $clog2(MAX_PAIRS_PER_ROW);
  localparam int EW    = CW + 1;
  localparam int WCMPW = (EW > CFG_W) ? EW : CFG_W;
  localparam int RW    = $clog2(2 * MAX_ROW_PAIRS);
  localparam int ERW   = $clog2(2 * MAX_ROW_PAIRS + 1);
  localparam int HCMPW = (ERW > CFG_W) ? ERW : CFG_W;

  // Zero counts as one, and sizes above the buffer limits saturate.
  function automatic logic [EW-1:0] clamp_width(input logic [CFG_W-1:0] v);
    logic [WCMPW-1:0] ve;
    ve = WCMPW'(v);
    if (v == '0) begin
      return EW'(1);
    end else if (ve > WCMPW'(MAX_PAIRS_PER_ROW)) begin
      return EW'(MAX_PAIRS_PER_ROW);
    end else begin
      return EW'(ve);
    end
  endfunction

  function automatic logic [ERW-1:0] clamp_rows(input logic [CFG_W-1:0] v);
    logic [HCMPW-1:0] ve;
    logic [ERW-1:0]   h;
    ve = HCMPW'(v);
    if (v == '0) begin
      h = ERW'(1);
    end else if (ve > HCMPW'(MAX_ROW_PAIRS)) begin
      h = ERW'(MAX_ROW_PAIRS);
    end else begin
      h = ERW'(ve);
    end
    return h << 1;
  endfunction

  logic [EW-1:0]  eff_width;
  logic [ERW-1:0] eff_rows;
  logic [CW-1:0]  column_count;
  logic [RW-1:0]  row_count;
  logic           accept;
  logic           row_end;
  logic           last_row;
  logic           odd_row;

  // Effective frame size, kept already clamped.
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_width <= clamp_width(WIDTH_PAIRS_RESET);
      eff_rows  <= clamp_rows(HEIGHT_PAIRS_RESET);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WIDTH_PAIRS:  eff_width <= clamp_width(cfg_data);
        REG_HEIGHT_PAIRS: eff_rows  <= clamp_rows(cfg_data);
        default: ;
      endcase
    end
  end

  // A transfer is taken only when the back part has room for it.
  assign in_stall = !room;
  assign accept   = in_valid && room;

  assign odd_row  = row_count[0];
  assign row_end  = (EW'(column_count) + EW'(1)) >= eff_width;
  assign last_row = (ERW'(row_count) + ERW'(1)) >= eff_rows;

  // Raster position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (row_end) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : RW'(row_count + RW'(1));
      end else begin
        column_count <= CW'(column_count + CW'(1));
      end
    end
  end

  // Even rows store half chroma; odd rows fetch it back.
  assign line_we    = accept && !odd_row;
  assign line_re    = accept && odd_row;
  assign line_addr  = column_count;
  assign line_wdata = {in_data.chroma_blue[7:1], in_data.chroma_red[7:1]};

  // Item register handed to the back part, aligned with the buffer read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_valid <= 1'b0;
    end else begin
      issue_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      issue.luma_first  <= in_data.luma_first;
      issue.luma_second <= in_data.luma_second;
      issue.pixel_row   <= 11'(row_count);
      issue.col_pair    <= 10'(column_count);
      issue.odd_row     <= odd_row;
      issue.frame_end   <= row_end && last_row;
      issue.blue_half   <= in_data.chroma_blue[7:1];
      issue.red_half    <= in_data.chroma_red[7:1];
    end
  end

endmodule

### hw/rtl/y2p_back.sv
module y2p_back import y2p_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              issue_valid,
  input  issue_t            issue,
  input  logic [LINE_W-1:0] line_rdata,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data
);

  out_item_t          queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               push;
  logic               pop;
  out_item_t          result;

  // Vertical chroma average on odd rows; even rows carry zero chroma.
  always_comb begin
    result.out_luma_first  = issue.luma_first;
    result.out_luma_second = issue.luma_second;
    result.pixel_row       = issue.pixel_row;
    result.col_pair        = issue.col_pair;
    result.chroma_valid    = issue.odd_row;
    result.frame_end       = issue.frame_end;
    if (issue.odd_row) begin
      result.out_chroma_blue = 8'(line_rdata[LINE_W-1:HALF_W]) + 8'(issue.blue_half);
      result.out_chroma_red  = 8'(line_rdata[HALF_W-1:0]) + 8'(issue.red_half);
    end else begin
      result.out_chroma_blue = '0;
      result.out_chroma_red  = '0;
    end
  end

  // Room counts the item already in the issue register, so a push never overflows.
  assign room = (count + QCNT_W'(issue_valid)) < QCNT_W'(QUEUE_DEPTH);

  assign push      = issue_valid;
  assign out_valid = count != '0;
  assign pop       = out_valid && !out_stall;
  assign out_data  = queue[rd_ptr];

  // Output queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= result;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= QPTR_W'(wr_ptr + QPTR_W'(1));
      end
      if (pop) begin
        rd_ptr <= QPTR_W'(rd_ptr + QPTR_W'(1));
      end
      count <= QCNT_W'(count + QCNT_W'(push) - QCNT_W'(pop));
    end
  end

  // The queue never holds more than its depth.
  assert property (@(posedge clk) disable iff (rst) count <= QCNT_W'(QUEUE_DEPTH))
    else $error("output queue over its depth");

  // An item arriving from the front always finds a free slot.
  assert property (@(posedge clk) disable iff (rst)
    push |-> (count < QCNT_W'(QUEUE_DEPTH)) || pop)
    else $error("push into a full output queue");

  // Averaged chroma appears only on odd rows.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.chroma_valid == out_data.pixel_row[0])
    else $error("chroma valid flag does not match row parity");

  // Even-row transfers carry zero chroma.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.chroma_valid) |->
      (out_data.out_chroma_blue == '0) && (out_data.out_chroma_red == '0))
    else $error("nonzero chroma on an even row");

endmodule
